/* src/spp_pkg.sv */
// spp_pkg: shared types and constants for the stepper position pulser.
// No dependencies; imported by every module of the block except spp_fifo.
package spp_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_HOME = 2'd2;

    // motion modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_SETTLE = 2'd1;
    localparam logic [1:0] MODE_STEP   = 2'd2;
    localparam logic [1:0] MODE_HOME   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_FULL_TRAVEL   = 3'd0;
    localparam logic [2:0] CFG_STEP_PERIOD   = 3'd1;
    localparam logic [2:0] CFG_HOMING_PERIOD = 3'd2;
    localparam logic [2:0] CFG_HOMING_EXTRA  = 3'd3;
    localparam logic [2:0] CFG_SETTLE        = 3'd4;

    // reset values
    localparam logic [15:0] RST_FULL_TRAVEL   = 16'd2000;
    localparam logic [19:0] RST_STEP_PERIOD   = 20'd1000;
    localparam logic [19:0] RST_HOMING_PERIOD = 20'd5000;
    localparam logic [15:0] RST_HOMING_EXTRA  = 16'd500;
    localparam logic [15:0] RST_SETTLE        = 16'd1000;

    // 100 percent in Q7.8
    localparam logic [14:0] PERCENT_FULL_Q8 = 15'd25600;
    // ceil(2^30 / 100): exact floor(y / 100) for y below 2^23
    localparam logic [23:0] RECIP_100   = 24'd10737419;
    localparam int          RECIP_SHIFT = 30;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] target;
    } t_cmd;

    typedef struct packed {
        logic        step_level;
        logic        direction_level;
        logic [15:0] position_steps;
        logic        busy_res;
        logic        command_ignored;
    } t_res;

    typedef struct packed {
        logic [15:0] full_travel;
        logic [19:0] step_period;
        logic [19:0] homing_period;
        logic [15:0] homing_extra;
        logic [15:0] settle;
    } t_cfg;

    // half of a pulse period, never below one tick
    function automatic logic [19:0] half_of(input logic [19:0] period);
        logic [19:0] h;
        h = {1'b0, period[19:1]};
        return (h == 20'd0) ? 20'd1 : h;
    endfunction

endpackage

/* src/spp_fifo.sv */
// spp_fifo: small register queue, first in first out, head shown combinationally.
// Depends on nothing; DEPTH must be a power of two.
module spp_fifo #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            if (do_push && !do_pop)      r_count <= r_count + CNT_W'(1);
            else if (do_pop && !do_push) r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end
endmodule

/* src/spp_front.sv */
// spp_front: accepts items, clamps the move target and scales it to steps.
// Two pipeline stages, one multiplier each. Uses spp_pkg.
module spp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_target_percent,
    input  logic [15:0]        i_full_travel,
    output logic               o_cmd_valid,
    output spp_pkg::t_cmd      o_cmd,
    output logic [1:0]         o_inflight
);
    import spp_pkg::*;

    logic [14:0] pc;
    logic [30:0] n_prod1;
    logic [46:0] n_prod2;
    logic [30:0] r_prod1;
    logic [46:0] r_prod2;
    logic [1:0]  r_kind1, r_kind2;
    logic        r_v1, r_v2;

    // clamp Q7.8 to 0..100 percent
    always_comb begin
        if (i_target_percent[15])                          pc = '0;
        else if (i_target_percent[14:0] > PERCENT_FULL_Q8) pc = PERCENT_FULL_Q8;
        else                                               pc = i_target_percent[14:0];
    end

    assign n_prod1 = 31'(pc) * 31'(i_full_travel);
    // divide by 25600: drop 8 bits, then reciprocal of 100
    assign n_prod2 = 47'(r_prod1[30:8]) * 47'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod1 <= n_prod1;
        r_kind1 <= i_kind;
        r_prod2 <= n_prod2;
        r_kind2 <= r_kind1;
    end

    assign o_cmd_valid   = r_v2;
    assign o_cmd.kind    = r_kind2;
    assign o_cmd.target  = r_prod2[RECIP_SHIFT+15:RECIP_SHIFT];
    assign o_inflight    = 2'(r_v1) + 2'(r_v2);
endmodule

/* src/spp_back.sv */
// spp_back: motion engine; carries out one queued item per cycle while the result
// queue has room, and builds its result. Uses spp_pkg.
module spp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spp_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  spp_pkg::t_cmd i_cmd,
    input  logic          i_res_room,
    output logic          o_cmd_take,
    output logic          o_res_valid,
    output spp_pkg::t_res o_res
);
    import spp_pkg::*;

    logic [15:0] r_position, n_position;
    logic        r_dir, n_dir;
    logic        r_pulse, n_pulse;
    logic [1:0]  r_mode, n_mode;
    logic [16:0] r_steps, n_steps;
    logic [19:0] r_timer, n_timer;

    logic        fire, ignored;
    logic [19:0] half_step, half_home, cur_half, t_dec;
    logic [16:0] s_dec, total;

    assign fire       = i_cmd_valid && i_res_room;
    assign half_step  = half_of(i_cfg.step_period);
    assign half_home  = half_of(i_cfg.homing_period);
    assign cur_half   = (r_mode == MODE_HOME) ? half_home : half_step;
    assign t_dec      = (r_timer != 20'd0) ? r_timer - 20'd1 : 20'd0;
    assign s_dec      = r_steps - 17'd1;
    assign total      = 17'(i_cfg.full_travel) + 17'(i_cfg.homing_extra);

    always_comb begin
        n_position = r_position;
        n_dir      = r_dir;
        n_pulse    = r_pulse;
        n_mode     = r_mode;
        n_steps    = r_steps;
        n_timer    = r_timer;
        ignored    = 1'b0;
        if (fire) begin
            unique case (i_cmd.kind)
                KIND_TICK: begin
                    if (r_mode != MODE_IDLE) begin
                        n_timer = t_dec;
                        if (t_dec == 20'd0) begin
                            if (r_mode == MODE_SETTLE) begin
                                n_mode  = MODE_STEP;
                                n_pulse = 1'b1;
                                n_timer = half_step;
                            end else if (r_pulse) begin
                                n_pulse = 1'b0;
                                n_timer = cur_half;
                            end else begin
                                if (r_mode == MODE_STEP)
                                    n_position = r_dir ? r_position + 16'd1
                                                       : r_position - 16'd1;
                                n_steps = s_dec;
                                if (s_dec == 17'd0) begin
                                    if (r_mode == MODE_HOME) n_position = '0;
                                    n_mode  = MODE_IDLE;
                                    n_timer = '0;
                                end else begin
                                    n_pulse = 1'b1;
                                    n_timer = cur_half;
                                end
                            end
                        end
                    end
                end
                KIND_MOVE: begin
                    if (r_mode != MODE_IDLE) begin
                        ignored = 1'b1;
                    end else if (i_cmd.target != r_position) begin
                        n_dir   = (i_cmd.target > r_position);
                        n_steps = n_dir ? 17'(i_cmd.target - r_position)
                                        : 17'(r_position - i_cmd.target);
                        if (i_cfg.settle == 16'd0) begin
                            n_mode  = MODE_STEP;
                            n_pulse = 1'b1;
                            n_timer = half_step;
                        end else begin
                            n_mode  = MODE_SETTLE;
                            n_pulse = 1'b0;
                            n_timer = 20'(i_cfg.settle);
                        end
                    end
                end
                KIND_HOME: begin
                    if (r_mode != MODE_IDLE) begin
                        ignored = 1'b1;
                    end else begin
                        n_dir = 1'b0;
                        if (total == 17'd0) begin
                            n_position = '0;
                        end else begin
                            n_steps = total;
                            n_mode  = MODE_HOME;
                            n_pulse = 1'b1;
                            n_timer = half_home;
                        end
                    end
                end
                default: ;  // unused code: report state only
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_dir      <= 1'b0;
            r_pulse    <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_steps    <= '0;
            r_timer    <= '0;
        end else begin
            r_position <= n_position;
            r_dir      <= n_dir;
            r_pulse    <= n_pulse;
            r_mode     <= n_mode;
            r_steps    <= n_steps;
            r_timer    <= n_timer;
        end
    end

    assign o_cmd_take            = fire;
    assign o_res_valid           = fire;
    assign o_res.step_level      = n_pulse;
    assign o_res.direction_level = n_dir;
    assign o_res.position_steps  = n_position;
    assign o_res.busy_res        = (n_mode != MODE_IDLE);
    assign o_res.command_ignored = ignored;
endmodule

/* src/stepper_position_pulser.sv */
// stepper_position_pulser: step/direction position controller, top level.
// Depends on spp_pkg, spp_fifo, spp_front and spp_back.
//
// Usage
//   Input queue: drive i_kind / i_target_percent with push; a transfer happens on a
//   clock edge with push high and full low. Kinds: tick, move, home.
//   Result queue: while empty is low the oldest result sits on the o_ ports; pop
//   high on an edge takes it. Exactly one result per input item, in order.
//   Config: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data; ready is
//   always high. Write only while the block holds no undelivered item.
// Timing
//   Path: a result is poppable once its input has passed two front stages for the
//   clamp and the two multiplies of the scaling, one queue register, then the motion
//   engine, which writes the result queue while it has room.
//   Throughput: one item per cycle while the result queue has room, set by the engine.
// Reset
//   Synchronous, active low: config registers return to their defaults, position zero,
//   motion idle, both queues empty.
// Stalls
//   If pop is held low the result queue fills, the engine stops, the command queue
//   fills, and full rises; nothing is lost and work resumes when pop returns.
module stepper_position_pulser #(
    parameter int QUEUE_DEPTH  = 4,   // command queue, power of two, at least 4
    parameter int RESULT_DEPTH = 2    // result queue, power of two
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input queue
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_target_percent,
    // result queue
    input  logic               pop,
    output logic               empty,
    output logic               o_step_level,
    output logic               o_direction_level,
    output logic [15:0]        o_position_steps,
    output logic               o_busy_res,
    output logic               o_command_ignored,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data
);
    import spp_pkg::*;

    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RCNT_W = $clog2(RESULT_DEPTH + 1);

    t_cfg  r_cfg;
    t_cmd  front_cmd, q_cmd;
    t_res  back_res, out_res;
    logic  front_valid, q_empty, q_full, q_take;
    logic  res_valid, res_full;
    logic  [1:0]        inflight;
    logic  [QCNT_W-1:0] q_count;
    logic  [RCNT_W-1:0] res_count;
    logic  [QCNT_W:0]   occupancy;
    logic  in_xfer;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_travel   <= RST_FULL_TRAVEL;
            r_cfg.step_period   <= RST_STEP_PERIOD;
            r_cfg.homing_period <= RST_HOMING_PERIOD;
            r_cfg.homing_extra  <= RST_HOMING_EXTRA;
            r_cfg.settle        <= RST_SETTLE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FULL_TRAVEL:   r_cfg.full_travel   <= i_cfg_data[15:0];
                CFG_STEP_PERIOD:   r_cfg.step_period   <= i_cfg_data;
                CFG_HOMING_PERIOD: r_cfg.homing_period <= i_cfg_data;
                CFG_HOMING_EXTRA:  r_cfg.homing_extra  <= i_cfg_data[15:0];
                CFG_SETTLE:        r_cfg.settle        <= i_cfg_data[15:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // credit check: items in the front pipe plus the queue never exceed its depth
    assign occupancy = {1'b0, q_count} + (QCNT_W + 1)'(inflight);
    assign full      = (occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign in_xfer   = push && !full;

    spp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (in_xfer),
        .i_kind           (i_kind),
        .i_target_percent (i_target_percent),
        .i_full_travel    (r_cfg.full_travel),
        .o_cmd_valid      (front_valid),
        .o_cmd            (front_cmd),
        .o_inflight       (inflight)
    );

    spp_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_cmd),
        .i_pop   (q_take),
        .o_data  (q_cmd),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    spp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_cmd),
        .i_res_room  (!res_full),
        .o_cmd_take  (q_take),
        .o_res_valid (res_valid),
        .o_res       (back_res)
    );

    spp_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (back_res),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty),
        .o_full  (res_full),
        .o_count (res_count)
    );

    assign o_step_level      = out_res.step_level;
    assign o_direction_level = out_res.direction_level;
    assign o_position_steps  = out_res.position_steps;
    assign o_busy_res        = out_res.busy_res;
    assign o_command_ignored = out_res.command_ignored;

`ifndef SYNTHESIS
    // the credit check must keep the command queue from overflowing
    a_cmd_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_valid |-> !q_full)
        else $error("command queue overflow");

    // engine only writes results when there is room
    a_res_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res_count != RCNT_W'(RESULT_DEPTH)))
        else $error("result queue overflow");

    // a dropped command implies the engine is still in motion
    a_ignored_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && back_res.command_ignored) |-> back_res.busy_res)
        else $error("command ignored while idle");

    // the step pin is never left high once motion has ended
    a_step_low_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && back_res.step_level) |-> back_res.busy_res)
        else $error("step pin high while idle");
`endif
endmodule

/* verif/spp_result_checker.sv */
`timescale 1ns / 100ps
// spp_result_checker: tracks the stepper pulser's motion state and checks every result.
// Depends on spp_pkg; instantiated beside the block by tb_stepper_position_pulser.
module spp_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_target_percent,
    input  logic               i_pop,
    input  logic               i_empty,
    input  logic               i_step_level,
    input  logic               i_direction_level,
    input  logic [15:0]        i_position_steps,
    input  logic               i_busy_res,
    input  logic               i_command_ignored,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output logic               o_motion_busy
);
    import spp_pkg::*;

    t_cfg        regs_q;
    logic [15:0] pos_q;
    logic        dir_q;
    logic        pulse_q;
    logic [1:0]  mode_q;
    logic [16:0] left_q;
    logic [19:0] timer_q;

    t_res        awaited_res[$];
    int          fails = 0;

    // length of the half period now in force, at least one tick
    function automatic logic [19:0] half_in_force();
        logic [19:0] period;
        period = (mode_q == MODE_HOME) ? regs_q.homing_period : regs_q.step_period;
        if (period < 20'd2)
            return 20'd1;
        return period >> 1;
    endfunction

    task automatic raise_pulse();
        pulse_q = 1'b1;
        timer_q = half_in_force();
    endtask

    task automatic tick_motion();
        if (mode_q == MODE_IDLE)
            return;
        if (timer_q != 20'd0)
            timer_q = timer_q - 20'd1;
        if (timer_q != 20'd0)
            return;
        if (mode_q == MODE_SETTLE) begin
            mode_q = MODE_STEP;
            raise_pulse();
            return;
        end
        if (pulse_q) begin
            pulse_q = 1'b0;
            timer_q = half_in_force();
            return;
        end
        // end of the low half: one step done
        if (mode_q == MODE_STEP)
            pos_q = dir_q ? pos_q + 16'd1 : pos_q - 16'd1;
        left_q = left_q - 17'd1;
        if (left_q == 17'd0) begin
            if (mode_q == MODE_HOME)
                pos_q = '0;
            mode_q  = MODE_IDLE;
            timer_q = '0;
        end else begin
            raise_pulse();
        end
    endtask

    task automatic start_move(input logic signed [15:0] pct);
        int          clamped;
        logic [31:0] prod;
        logic [15:0] goal;
        clamped = int'(pct);
        if (clamped < 0)
            clamped = 0;
        if (clamped > int'(PERCENT_FULL_Q8))
            clamped = int'(PERCENT_FULL_Q8);
        prod = clamped * regs_q.full_travel;
        goal = prod / PERCENT_FULL_Q8;
        if (goal == pos_q)
            return;
        dir_q  = (goal > pos_q);
        left_q = dir_q ? goal - pos_q : pos_q - goal;
        if (regs_q.settle == 16'd0) begin
            mode_q = MODE_STEP;
            raise_pulse();
        end else begin
            mode_q  = MODE_SETTLE;
            pulse_q = 1'b0;
            timer_q = regs_q.settle;
        end
    endtask

    task automatic start_homing();
        logic [16:0] total;
        total = regs_q.full_travel + regs_q.homing_extra;
        dir_q = 1'b0;
        if (total == 17'd0) begin
            pos_q = '0;
            return;
        end
        left_q = total;
        mode_q = MODE_HOME;
        raise_pulse();
    endtask

    // applies one item to the tracked state and returns the result it must produce
    task automatic advance_motion(input logic [1:0] kind, input logic signed [15:0] pct,
                                  output t_res res);
        logic dropped;
        dropped = 1'b0;
        case (kind)
            KIND_TICK: tick_motion();
            KIND_MOVE, KIND_HOME: begin
                if (mode_q != MODE_IDLE)
                    dropped = 1'b1;
                else if (kind == KIND_MOVE)
                    start_move(pct);
                else
                    start_homing();
            end
            default: ;
        endcase
        res.step_level      = pulse_q;
        res.direction_level = dir_q;
        res.position_steps  = pos_q;
        res.busy_res        = (mode_q != MODE_IDLE);
        res.command_ignored = dropped;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            regs_q.full_travel   = RST_FULL_TRAVEL;
            regs_q.step_period   = RST_STEP_PERIOD;
            regs_q.homing_period = RST_HOMING_PERIOD;
            regs_q.homing_extra  = RST_HOMING_EXTRA;
            regs_q.settle        = RST_SETTLE;
            pos_q   = '0;
            dir_q   = 1'b0;
            pulse_q = 1'b0;
            mode_q  = MODE_IDLE;
            left_q  = '0;
            timer_q = '0;
            awaited_res.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (awaited_res.size() == 0) begin
                    $display("%0t: result with nothing awaited, position %0d", $time,
                             i_position_steps);
                    fails++;
                end else begin
                    want = awaited_res.pop_front();
                    check_field("step_level", want.step_level, i_step_level);
                    check_field("direction_level", want.direction_level, i_direction_level);
                    check_field("position_steps", want.position_steps, i_position_steps);
                    check_field("busy_res", want.busy_res, i_busy_res);
                    check_field("command_ignored", want.command_ignored, i_command_ignored);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FULL_TRAVEL:   regs_q.full_travel   = i_cfg_data[15:0];
                    CFG_STEP_PERIOD:   regs_q.step_period   = i_cfg_data;
                    CFG_HOMING_PERIOD: regs_q.homing_period = i_cfg_data;
                    CFG_HOMING_EXTRA:  regs_q.homing_extra  = i_cfg_data[15:0];
                    CFG_SETTLE:        regs_q.settle        = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                advance_motion(i_kind, i_target_percent, want);
                awaited_res.push_back(want);
            end
        end
        o_pending     <= awaited_res.size();
        o_motion_busy <= (mode_q != MODE_IDLE);
        o_fail_count  <= fails;
    end

endmodule

/* verif/tb_stepper_position_pulser.sv */
`timescale 1ns / 100ps
// tb_stepper_position_pulser: stimulus and verdict for the stepper position pulser.
// Depends on spp_pkg, stepper_position_pulser and spp_result_checker.
module tb_stepper_position_pulser;
    import spp_pkg::*;

    // codes with no name in the package: the spare item kind and a register hole
    localparam logic [1:0] KIND_NONE   = 2'd3;
    localparam logic [2:0] CFG_NONE    = 3'd7;
    localparam int         HOLD_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT = 200_000;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               push             = 1'b0;
    logic               full;
    logic [1:0]         i_kind           = KIND_TICK;
    logic signed [15:0] i_target_percent = '0;
    logic               pop              = 1'b0;
    logic               empty;
    logic               o_step_level;
    logic               o_direction_level;
    logic [15:0]        o_position_steps;
    logic               o_busy_res;
    logic               o_command_ignored;
    logic               i_cfg_valid      = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index      = CFG_FULL_TRAVEL;
    logic [19:0]        i_cfg_data       = '0;

    int          fail_count;
    int          pending;
    logic        motion_busy;

    // idling odds, in percent, changed between regimes
    int          send_idle_pct = 11;
    int          recv_idle_pct = 56;
    // ask the receiver for one long hold-off: a toggle, taken up by the receiver
    bit          stall_req     = 1'b0;
    bit          stall_ack     = 1'b0;
    int          hold_left     = 0;
    // ticks and accepted-while-idle commands sent so far
    int          work_items    = 0;
    int unsigned cycle_cnt     = 0;

    always #10 i_clk = ~i_clk;

    stepper_position_pulser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_kind           (i_kind),
        .i_target_percent (i_target_percent),
        .pop              (pop),
        .empty            (empty),
        .o_step_level     (o_step_level),
        .o_direction_level(o_direction_level),
        .o_position_steps (o_position_steps),
        .o_busy_res       (o_busy_res),
        .o_command_ignored(o_command_ignored),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    spp_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_kind           (i_kind),
        .i_target_percent (i_target_percent),
        .i_pop            (pop),
        .i_empty          (empty),
        .i_step_level     (o_step_level),
        .i_direction_level(o_direction_level),
        .i_position_steps (o_position_steps),
        .i_busy_res       (o_busy_res),
        .i_command_ignored(o_command_ignored),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_motion_busy    (motion_busy)
    );

    // Result side: random pop, or a long hold-off counted here when asked for.
    // The sender keeps offering during the hold so the queues fill and full rises.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_req != stall_ack) begin
            stall_ack <= stall_req;
            hold_left <= HOLD_CYCLES;
            pop       <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a hung handshake or a result that never comes ends here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[stepper_position_pulser] ERROR");
            $finish;
        end
    end

    // Offer one item, with random idle cycles first; returns at the edge of its transfer.
    task automatic send_item(input logic [1:0] kind, input logic [15:0] pct);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_kind           <= kind;
        i_target_percent <= pct;
        do @(posedge i_clk); while (full);
    endtask

    // Stop sending and wait for every awaited result to be popped.
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Valid stays high across back-to-back writes; the caller lowers it.
    task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Full register set, written only once the block is drained. Unused upper
    // data bits of the 16-bit registers carry junk, and the hole at the top
    // of the index space gets a write too.
    task automatic set_cfg(input logic [15:0] travel, input logic [19:0] step_p,
                           input logic [19:0] home_p, input logic [15:0] extra,
                           input logic [15:0] settle);
        drain();
        write_reg(CFG_FULL_TRAVEL, {4'($urandom), travel});
        write_reg(CFG_STEP_PERIOD, step_p);
        write_reg(CFG_HOMING_PERIOD, home_p);
        write_reg(CFG_HOMING_EXTRA, {4'($urandom), extra});
        write_reg(CFG_SETTLE, {4'($urandom), settle});
        write_reg(CFG_NONE, 20'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Tick until the tracked motion is over. The busy flag seen at a transfer
    // lags by one item, so the first tick is unconditional and one spare idle
    // tick may follow. With noise on, stray commands (dropped while busy) and
    // spare-kind items are mixed in.
    task automatic run_to_idle(input bit noisy);
        int roll;
        send_item(KIND_TICK, 16'($urandom));
        work_items++;
        while (motion_busy) begin
            roll = $urandom_range(99);
            if (noisy && roll < 4) begin
                send_item($urandom_range(1) ? KIND_HOME : KIND_MOVE, 16'($urandom));
            end else if (noisy && roll < 7) begin
                send_item(KIND_NONE, 16'($urandom));
            end else begin
                send_item(KIND_TICK, 16'($urandom));
                work_items++;
            end
        end
    endtask

    // Random registers kept small so that moves stay short, then whole
    // command sequences: command, ticks to completion, sometimes idle ticks.
    task automatic random_phase(input int budget, input bit squeeze);
        int stop_at;
        int roll;
        set_cfg(16'($urandom_range(24, 1)), 20'($urandom_range(6)), 20'($urandom_range(6)),
                16'($urandom_range(5)), 16'($urandom_range(4)));
        if (squeeze)
            stall_req <= ~stall_req;
        stop_at = work_items + budget;
        while (work_items < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 60)
                send_item(KIND_MOVE, 16'($urandom_range(25600)));
            else if (roll < 75)
                send_item(KIND_MOVE, 16'($urandom));
            else if (roll < 93)
                send_item(KIND_HOME, 16'($urandom));
            else
                send_item(KIND_NONE, 16'($urandom));
            if (roll < 93)
                work_items++;
            run_to_idle(1'b1);
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(3, 1)) begin
                    send_item(KIND_TICK, 16'($urandom));
                    work_items++;
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, on reset registers: nothing may move ---
        send_item(KIND_TICK, 16'h0000);          // tick while idle
        send_item(KIND_MOVE, 16'h0000);          // target equals position
        send_item(KIND_NONE, 16'hFFFF);          // spare kind code
        send_item(KIND_MOVE, 16'h8000);          // most negative percent, clamps to zero

        // zero settle: first pulse rises with the move itself
        set_cfg(16'd10, 20'd4, 20'd6, 16'd3, 16'd0);
        send_item(KIND_MOVE, 16'd12800);         // 50 percent
        send_item(KIND_TICK, 16'h0000);
        send_item(KIND_MOVE, 16'h7FFF);          // dropped, busy
        send_item(KIND_HOME, 16'h0000);          // dropped, busy
        run_to_idle(1'b0);
        send_item(KIND_MOVE, 16'h7FFF);          // above 100 percent, clamps
        run_to_idle(1'b0);
        send_item(KIND_MOVE, 16'h0001);          // rounds down to zero, closing
        run_to_idle(1'b0);
        send_item(KIND_HOME, 16'h0000);
        run_to_idle(1'b0);

        // settle wait, odd step period, homing period below two
        set_cfg(16'd7, 20'd5, 20'd1, 16'd0, 16'd3);
        send_item(KIND_MOVE, 16'd25600);
        run_to_idle(1'b0);
        send_item(KIND_MOVE, 16'h8000);
        run_to_idle(1'b0);
        send_item(KIND_HOME, 16'h0000);
        run_to_idle(1'b0);

        // zero homing length, zero periods, zero travel
        set_cfg(16'd0, 20'd0, 20'd0, 16'd0, 16'd2);
        send_item(KIND_HOME, 16'h0000);
        send_item(KIND_MOVE, 16'd25600);
        send_item(KIND_TICK, 16'h0000);

        // --- random: sender idles lightly, receiver heavily ---
        random_phase(80, 1'b0);
        random_phase(80, 1'b1);                  // includes the long receiver hold
        random_phase(80, 1'b0);

        // --- receiver idles lightly, sender heavily ---
        send_idle_pct = 56;
        recv_idle_pct = 11;
        random_phase(80, 1'b0);
        random_phase(80, 1'b0);
        random_phase(80, 1'b0);

        // --- no idling on either side ---
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(60, 1'b0);

        // full-scale registers: smallest nonzero percent at full travel is two steps,
        // after a settle wait
        set_cfg(16'hFFFF, 20'd2, 20'd1000000, 16'hFFFF, 16'd40);
        send_item(KIND_MOVE, 16'h0001);
        run_to_idle(1'b0);
        // short homing pass at an odd homing period
        set_cfg(16'd3, 20'd1000000, 20'd3, 16'd2, 16'd0);
        send_item(KIND_HOME, 16'h0000);
        run_to_idle(1'b0);

        drain();
        repeat (10) @(posedge i_clk);            // catch any stray result
        if (fail_count == 0)
            $display("[stepper_position_pulser] OK");
        else
            $display("[stepper_position_pulser] ERROR");
        $finish;
    end

endmodule
